### hdl/otst_pkg.sv
`timescale 1ns / 1ps

package otst_pkg;

  // Table geometry.
  localparam int NumTimers = 16;
  localparam int MaxOut    = 16;
  localparam int IdxW      = (NumTimers > 1) ? $clog2(NumTimers) : 1;
  localparam int CntW      = $clog2(MaxOut + 1);

  // Field widths.
  localparam int OpW    = 3;
  localparam int KindW  = 3;
  localparam int IdW    = 16;
  localparam int IvW    = 16;
  localparam int TimeW  = 32;
  localparam int DataW  = 32;

  // Stream payload widths.
  localparam int InDataW   = IvW + IdW + DataW;
  localparam int OutFieldW = 1 + IdW + DataW;
  localparam int OutDataW  = ((OutFieldW + 7) / 8) * 8;

  // Command opcodes.
  localparam logic [OpW-1:0] OpAdd     = 3'd0;
  localparam logic [OpW-1:0] OpRestart = 3'd1;
  localparam logic [OpW-1:0] OpRemove  = 3'd2;
  localparam logic [OpW-1:0] OpTick    = 3'd3;
  localparam logic [OpW-1:0] OpStart   = 3'd4;
  localparam logic [OpW-1:0] OpStop    = 3'd5;

  // Result kinds.
  localparam logic [KindW-1:0] KindAdded     = 3'd0;
  localparam logic [KindW-1:0] KindRestarted = 3'd1;
  localparam logic [KindW-1:0] KindRemoved   = 3'd2;
  localparam logic [KindW-1:0] KindFired     = 3'd3;
  localparam logic [KindW-1:0] KindStarted   = 3'd4;
  localparam logic [KindW-1:0] KindStopped   = 3'd5;

  localparam logic [IdW-1:0] FirstId = 16'd1;

  // Write request into the slot table.
  typedef struct packed {
    logic            add;
    logic            rearm;
    logic            load_data;
    logic            clear;
    logic [IdxW-1:0] idx;
    logic [IdW-1:0]  id;
    logic [IvW-1:0]  interval;
    logic [TimeW-1:0] deadline;
    logic [DataW-1:0] data;
  } otst_wr_t;

  // One slot as seen on the read port.
  typedef struct packed {
    logic             valid;
    logic [IdW-1:0]   id;
    logic [IvW-1:0]   interval;
    logic [TimeW-1:0] deadline;
    logic [DataW-1:0] data;
  } otst_slot_t;

endpackage

### hdl/otst_store.sv
`timescale 1ns / 1ps

module otst_store (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  otst_pkg::otst_wr_t            wr_i,
  input  logic [otst_pkg::IdxW-1:0]     rd_idx_i,
  output otst_pkg::otst_slot_t          rd_o,
  output logic                          any_free_o,
  output logic [otst_pkg::IdxW-1:0]     free_idx_o
);
  import otst_pkg::*;

  logic [NumTimers-1:0] valid_q;
  logic [IdW-1:0]   slot_id_q       [NumTimers];
  logic [IvW-1:0]   slot_interval_q [NumTimers];
  logic [TimeW-1:0] slot_deadline_q [NumTimers];
  logic [DataW-1:0] slot_data_q     [NumTimers];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (wr_i.add) begin
        valid_q[wr_i.idx] <= 1'b1;
      end else if (wr_i.clear) begin
        valid_q[wr_i.idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.add) begin
      slot_id_q[wr_i.idx]       <= wr_i.id;
      slot_interval_q[wr_i.idx] <= wr_i.interval;
    end
    if (wr_i.add || wr_i.rearm) begin
      slot_deadline_q[wr_i.idx] <= wr_i.deadline;
    end
    if (wr_i.add || wr_i.load_data) begin
      slot_data_q[wr_i.idx] <= wr_i.data;
    end
  end

  assign rd_o.valid    = valid_q[rd_idx_i];
  assign rd_o.id       = slot_id_q[rd_idx_i];
  assign rd_o.interval = slot_interval_q[rd_idx_i];
  assign rd_o.deadline = slot_deadline_q[rd_idx_i];
  assign rd_o.data     = slot_data_q[rd_idx_i];

  // Lowest free slot wins.
  always_comb begin
    free_idx_o = '0;
    for (int i = NumTimers - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_idx_o = IdxW'(i);
      end
    end
  end

  assign any_free_o = ~&valid_q;

endmodule

### hdl/otst_unit.sv
`timescale 1ns / 1ps

module otst_unit (
  input  logic [otst_pkg::TimeW-1:0] now_i,
  input  logic [otst_pkg::IvW-1:0]   interval_i,
  input  otst_pkg::otst_slot_t       slot_i,
  input  logic [otst_pkg::IdW-1:0]   key_i,
  input  logic                       best_v_i,
  input  logic [otst_pkg::TimeW-1:0] best_late_i,
  input  logic [otst_pkg::IdW-1:0]   best_id_i,
  output logic [otst_pkg::TimeW-1:0] deadline_o,
  output logic [otst_pkg::TimeW-1:0] late_o,
  output logic                       match_o,
  output logic                       better_o
);
  import otst_pkg::*;

  logic [TimeW-1:0] diff;
  logic             expired;

  assign deadline_o = now_i + TimeW'(interval_i);

  // Wrap-aware: the difference read as a signed value must be positive.
  assign diff    = now_i - slot_i.deadline;
  assign expired = slot_i.valid && !diff[TimeW-1] && (diff != '0);
  assign late_o  = diff;

  assign match_o = slot_i.valid && (slot_i.id == key_i);

  assign better_o = expired && (!best_v_i || (diff > best_late_i) ||
                    ((diff == best_late_i) && (slot_i.id < best_id_i)));

endmodule

### hdl/one_shot_timer_table.sv
`timescale 1ns / 1ps

// Table of one-shot millisecond timers driven by a command stream.
// The slave channel carries one command per transaction: tuser holds the
// opcode (add, restart, remove, tick, start, stop) and tdata holds the
// interval, the timer id and the payload. The master channel returns the
// results: tuser holds the result kind, tdata the ok flag, the id and the
// payload, and tlast marks the final result of a command.
// Add writes a free slot in its own state and then emits its result; stop
// emits its result straight away. Restart and remove walk the slots one per
// cycle until the id matches or the last slot is checked; start re-arms every
// valid slot in turn and answers after the last one.
// A tick walks the whole table once per fired timer through one shared
// subtract-and-compare unit, plus one final walk that finds nothing unless
// the sixteenth fire ends the tick, so a tick fires at most 16 timers. A tick
// that fires nothing returns no result. The slave side accepts only while no
// command is being worked on; a finished result may still sit in the output
// register then.
// Reset clears the clock, the running flag and all slot valid bits, and
// sets the next id to one. When the receiver stalls, the sequencer holds
// its pending result and waits.

module one_shot_timer_table (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // tdata: interval_ms [15:0], timer_id [31:16], seq_data [63:32]
  input  logic [otst_pkg::InDataW-1:0]   s_axis_tdata_i,
  // tuser: opcode [2:0]
  input  logic [otst_pkg::OpW-1:0]       s_axis_tuser_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // tdata: ok [0], out_id [16:1], out_data [48:17], zero fill [55:49]
  output logic [otst_pkg::OutDataW-1:0]  m_axis_tdata_o,
  // tuser: kind [2:0]
  output logic [otst_pkg::KindW-1:0]     m_axis_tuser_o,
  output logic                           m_axis_tlast_o
);
  import otst_pkg::*;

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StAdd   = 4'd1;
  localparam logic [3:0] StFind  = 4'd2;
  localparam logic [3:0] StStart = 4'd3;
  localparam logic [3:0] StEmit  = 4'd4;
  localparam logic [3:0] StScan  = 4'd5;
  localparam logic [3:0] StPick  = 4'd6;
  localparam logic [3:0] StFlush = 4'd7;

  localparam logic [IdxW-1:0] LastIdx = IdxW'(NumTimers - 1);
  localparam logic [CntW-1:0] LastCnt = CntW'(MaxOut - 1);

  logic [3:0] state_q, state_d;

  // Latched command.
  logic [OpW-1:0]   op_q, op_d;
  logic [IvW-1:0]   interval_q, interval_d;
  logic [IdW-1:0]   tid_q, tid_d;
  logic [DataW-1:0] cmd_data_q, cmd_data_d;

  // Architectural state.
  logic [TimeW-1:0] now_q, now_d;
  logic [IdW-1:0]   next_id_q, next_id_d;
  logic             running_q, running_d;

  // Scan pointer and tick bookkeeping.
  logic [IdxW-1:0]  idx_q, idx_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             best_v_q, best_v_d;
  logic [IdxW-1:0]  best_idx_q, best_idx_d;
  logic [TimeW-1:0] best_late_q, best_late_d;
  logic [IdW-1:0]   best_id_q, best_id_d;
  logic [DataW-1:0] best_data_q, best_data_d;
  logic             held_v_q, held_v_d;
  logic [IdW-1:0]   held_id_q, held_id_d;
  logic [DataW-1:0] held_data_q, held_data_d;

  // Single result waiting for the output register.
  logic [KindW-1:0] res_kind_q, res_kind_d;
  logic             res_ok_q, res_ok_d;
  logic [IdW-1:0]   res_id_q, res_id_d;

  // Output register.
  logic             m_valid_q, m_valid_d;
  logic [KindW-1:0] m_kind_q, m_kind_d;
  logic             m_ok_q, m_ok_d;
  logic [IdW-1:0]   m_id_q, m_id_d;
  logic [DataW-1:0] m_data_q, m_data_d;
  logic             m_last_q, m_last_d;

  otst_wr_t         wr;
  otst_slot_t       rd;
  logic [IdxW-1:0]  rd_idx;
  logic             any_free;
  logic [IdxW-1:0]  free_idx;
  logic [IvW-1:0]   unit_interval;
  logic [TimeW-1:0] unit_deadline;
  logic [TimeW-1:0] unit_late;
  logic             unit_match;
  logic             unit_better;
  logic             in_fire;
  logic             out_free;
  logic [IdW-1:0]   id_inc;

  otst_store u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_i       (wr),
    .rd_idx_i   (rd_idx),
    .rd_o       (rd),
    .any_free_o (any_free),
    .free_idx_o (free_idx)
  );

  otst_unit u_unit (
    .now_i       (now_q),
    .interval_i  (unit_interval),
    .slot_i      (rd),
    .key_i       (tid_q),
    .best_v_i    (best_v_q),
    .best_late_i (best_late_q),
    .best_id_i   (best_id_q),
    .deadline_o  (unit_deadline),
    .late_o      (unit_late),
    .match_o     (unit_match),
    .better_o    (unit_better)
  );

  assign rd_idx        = idx_q;
  assign unit_interval = (state_q == StAdd) ? interval_q : rd.interval;
  assign out_free      = !m_valid_q || m_axis_tready_i;
  assign in_fire       = s_axis_tvalid_i && s_axis_tready_o;
  assign id_inc        = next_id_q + FirstId;

  assign s_axis_tready_o = (state_q == StIdle);

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    interval_d  = interval_q;
    tid_d       = tid_q;
    cmd_data_d  = cmd_data_q;
    now_d       = now_q;
    next_id_d   = next_id_q;
    running_d   = running_q;
    idx_d       = idx_q;
    cnt_d       = cnt_q;
    best_v_d    = best_v_q;
    best_idx_d  = best_idx_q;
    best_late_d = best_late_q;
    best_id_d   = best_id_q;
    best_data_d = best_data_q;
    held_v_d    = held_v_q;
    held_id_d   = held_id_q;
    held_data_d = held_data_q;
    res_kind_d  = res_kind_q;
    res_ok_d    = res_ok_q;
    res_id_d    = res_id_q;

    m_valid_d = m_valid_q && !m_axis_tready_i;
    m_kind_d  = m_kind_q;
    m_ok_d    = m_ok_q;
    m_id_d    = m_id_q;
    m_data_d  = m_data_q;
    m_last_d  = m_last_q;

    wr           = '0;
    wr.idx       = idx_q;
    wr.id        = next_id_q;
    wr.interval  = interval_q;
    wr.deadline  = unit_deadline;
    wr.data      = cmd_data_q;

    case (state_q)
      StIdle: begin
        if (in_fire) begin
          op_d       = s_axis_tuser_i;
          interval_d = s_axis_tdata_i[IvW-1:0];
          tid_d      = s_axis_tdata_i[IvW +: IdW];
          cmd_data_d = s_axis_tdata_i[IvW+IdW +: DataW];
          idx_d      = '0;
          case (s_axis_tuser_i)
            OpAdd: begin
              state_d = StAdd;
            end
            OpRestart, OpRemove: begin
              state_d = StFind;
            end
            OpTick: begin
              now_d = now_q + TimeW'(1);
              if (running_q) begin
                best_v_d = 1'b0;
                held_v_d = 1'b0;
                cnt_d    = '0;
                state_d  = StScan;
              end
            end
            OpStart: begin
              state_d = StStart;
            end
            OpStop: begin
              running_d  = 1'b0;
              res_kind_d = KindStopped;
              res_ok_d   = 1'b1;
              res_id_d   = s_axis_tdata_i[IvW +: IdW];
              state_d    = StEmit;
            end
            default: begin
              state_d = StIdle;
            end
          endcase
        end
      end

      StAdd: begin
        res_kind_d = KindAdded;
        if (any_free) begin
          wr.add    = 1'b1;
          wr.idx    = free_idx;
          res_ok_d  = 1'b1;
          res_id_d  = next_id_q;
          // Zero is never handed out as an id.
          next_id_d = (id_inc == '0) ? FirstId : id_inc;
        end else begin
          res_ok_d = 1'b0;
          res_id_d = '0;
        end
        state_d = StEmit;
      end

      StFind: begin
        res_kind_d = (op_q == OpRestart) ? KindRestarted : KindRemoved;
        res_id_d   = tid_q;
        if (unit_match) begin
          if (op_q == OpRestart) begin
            wr.rearm     = 1'b1;
            wr.load_data = 1'b1;
          end else begin
            wr.clear = 1'b1;
          end
          res_ok_d = 1'b1;
          state_d  = StEmit;
        end else if (idx_q == LastIdx) begin
          res_ok_d = 1'b0;
          state_d  = StEmit;
        end else begin
          idx_d = idx_q + IdxW'(1);
        end
      end

      StStart: begin
        wr.rearm = rd.valid;
        if (idx_q == LastIdx) begin
          running_d  = 1'b1;
          res_kind_d = KindStarted;
          res_ok_d   = 1'b1;
          res_id_d   = tid_q;
          state_d    = StEmit;
        end else begin
          idx_d = idx_q + IdxW'(1);
        end
      end

      StEmit: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_kind_d  = res_kind_q;
          m_ok_d    = res_ok_q;
          m_id_d    = res_id_q;
          m_data_d  = '0;
          m_last_d  = 1'b1;
          state_d   = StIdle;
        end
      end

      StScan: begin
        if (unit_better) begin
          best_v_d    = 1'b1;
          best_idx_d  = idx_q;
          best_late_d = unit_late;
          best_id_d   = rd.id;
          best_data_d = rd.data;
        end
        if (idx_q == LastIdx) begin
          state_d = StPick;
        end else begin
          idx_d = idx_q + IdxW'(1);
        end
      end

      // A fire is held back one walk so that the final one can carry tlast.
      StPick: begin
        if (!best_v_q) begin
          if (!held_v_q) begin
            state_d = StIdle;
          end else if (out_free) begin
            m_valid_d = 1'b1;
            m_kind_d  = KindFired;
            m_ok_d    = 1'b1;
            m_id_d    = held_id_q;
            m_data_d  = held_data_q;
            m_last_d  = 1'b1;
            held_v_d  = 1'b0;
            state_d   = StIdle;
          end
        end else if (!held_v_q || out_free) begin
          if (held_v_q) begin
            m_valid_d = 1'b1;
            m_kind_d  = KindFired;
            m_ok_d    = 1'b1;
            m_id_d    = held_id_q;
            m_data_d  = held_data_q;
            m_last_d  = 1'b0;
          end
          wr.clear    = 1'b1;
          wr.idx      = best_idx_q;
          held_v_d    = 1'b1;
          held_id_d   = best_id_q;
          held_data_d = best_data_q;
          cnt_d       = cnt_q + CntW'(1);
          best_v_d    = 1'b0;
          idx_d       = '0;
          state_d     = (cnt_q == LastCnt) ? StFlush : StScan;
        end
      end

      StFlush: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_kind_d  = KindFired;
          m_ok_d    = 1'b1;
          m_id_d    = held_id_q;
          m_data_d  = held_data_q;
          m_last_d  = 1'b1;
          held_v_d  = 1'b0;
          state_d   = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      now_q     <= '0;
      next_id_q <= FirstId;
      running_q <= 1'b0;
      idx_q     <= '0;
      cnt_q     <= '0;
      best_v_q  <= 1'b0;
      held_v_q  <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      now_q     <= now_d;
      next_id_q <= next_id_d;
      running_q <= running_d;
      idx_q     <= idx_d;
      cnt_q     <= cnt_d;
      best_v_q  <= best_v_d;
      held_v_q  <= held_v_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    interval_q  <= interval_d;
    tid_q       <= tid_d;
    cmd_data_q  <= cmd_data_d;
    best_idx_q  <= best_idx_d;
    best_late_q <= best_late_d;
    best_id_q   <= best_id_d;
    best_data_q <= best_data_d;
    held_id_q   <= held_id_d;
    held_data_q <= held_data_d;
    res_kind_q  <= res_kind_d;
    res_ok_q    <= res_ok_d;
    res_id_q    <= res_id_d;
    m_kind_q    <= m_kind_d;
    m_ok_q      <= m_ok_d;
    m_id_q      <= m_id_d;
    m_data_q    <= m_data_d;
    m_last_q    <= m_last_d;
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tuser_o  = m_kind_q;
  assign m_axis_tlast_o  = m_last_q;
  assign m_axis_tdata_o  = {{(OutDataW - OutFieldW){1'b0}}, m_data_q, m_id_q, m_ok_q};

endmodule
